[design/pos_pkg.sv]
// shared types and codes for the priority ordered stack
`timescale 1ns / 1ps

package pos_pkg;

	// command codes carried on kind
	typedef enum logic [1:0] {
		KIND_SORT  = 2'd0,
		KIND_FRONT = 2'd1,
		KIND_POP   = 2'd2
	} kind_t;

	// status codes reported with each result word
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

[design/pos_ctrl.sv]
// controller state machine for the priority ordered stack
`timescale 1ns / 1ps

module pos_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output pos_pkg::cmd_t  cmd
);

	pos_pkg::state_t state_q;
	pos_pkg::state_t state_nxt;
	logic            done_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pos_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result strobe follows the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	// next state and command decode
	always_comb begin
		state_nxt = state_q;
		busy      = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		case (state_q)
			pos_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = pos_pkg::ST_EXEC;
				end
			end
			pos_pkg::ST_EXEC: begin
				busy      = 1'b1;
				cmd.exec  = 1'b1;
				state_nxt = pos_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = pos_pkg::ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

[design/pos_datapath.sv]
// row of ordered cells with compare, shift and result registers
`timescale 1ns / 1ps

module pos_datapath #(
	parameter int DEPTH = 16,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pos_pkg::cmd_t        cmd,
	input  logic [1:0]           kind,
	input  logic signed [31:0]   item_value,
	input  logic signed [31:0]   item_rank,
	output logic signed [31:0]   head_value,
	output logic signed [31:0]   head_rank,
	output logic                 popped,
	output logic [1:0]           status,
	output logic [CW-1:0]        fill_count
);

	logic [1:0]         kind_q;
	logic signed [31:0] value_q;
	logic signed [31:0] rank_q;
	logic [CW-1:0]      occ_q;

	logic signed [31:0] cell_value_q [DEPTH];
	logic signed [31:0] cell_rank_q  [DEPTH];
	logic signed [31:0] cell_value_nxt [DEPTH];
	logic signed [31:0] cell_rank_nxt  [DEPTH];

	logic [DEPTH-1:0] rank_hit;
	logic [DEPTH-1:0] after_pos;
	logic             is_push;
	logic             is_pop;
	logic             full;
	logic             empty;
	logic             push_ok;
	logic             pop_ok;

	logic signed [31:0] head_value_q;
	logic signed [31:0] head_rank_q;
	logic               popped_q;
	logic [1:0]         status_q;

	// command word capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			value_q <= item_value;
			rank_q  <= item_rank;
		end
	end

	// command decode
	assign is_push = (kind_q == pos_pkg::KIND_SORT) || (kind_q == pos_pkg::KIND_FRONT);
	assign is_pop  = (kind_q == pos_pkg::KIND_POP);
	assign full    = (occ_q == CW'(DEPTH));
	assign empty   = (occ_q == '0);
	assign push_ok = cmd.exec && is_push && !full;
	assign pop_ok  = cmd.exec && is_pop && !empty;

	// each cell flags a greater rank, an empty slot or a head push
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			rank_hit[i] = (CW'(i) >= occ_q) || (kind_q == pos_pkg::KIND_FRONT) ||
				(cell_rank_q[i] > rank_q);
		end
	end

	// cells at or after the first hit take part in the shift
	always_comb begin
		after_pos[0] = rank_hit[0];
		for (int i = 1; i < DEPTH; i++) begin
			after_pos[i] = after_pos[i - 1] || rank_hit[i];
		end
	end

	// per cell next value: keep, take new word, shift down or shift up
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_value_nxt[i] = cell_value_q[i];
			cell_rank_nxt[i]  = cell_rank_q[i];
			if (push_ok && after_pos[i]) begin
				if (i == 0) begin
					cell_value_nxt[i] = value_q;
					cell_rank_nxt[i]  = rank_q;
				end else if (!after_pos[(i == 0) ? 0 : i - 1]) begin
					cell_value_nxt[i] = value_q;
					cell_rank_nxt[i]  = rank_q;
				end else begin
					cell_value_nxt[i] = cell_value_q[(i == 0) ? 0 : i - 1];
					cell_rank_nxt[i]  = cell_rank_q[(i == 0) ? 0 : i - 1];
				end
			end else if (pop_ok && (i < DEPTH - 1)) begin
				cell_value_nxt[i] = cell_value_q[(i < DEPTH - 1) ? i + 1 : i];
				cell_rank_nxt[i]  = cell_rank_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	// cell row storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_value_q[i] <= cell_value_nxt[i];
			cell_rank_q[i]  <= cell_rank_nxt[i];
		end
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (push_ok) begin
			occ_q <= occ_q + CW'(1);
		end else if (pop_ok) begin
			occ_q <= occ_q - CW'(1);
		end
	end

	// result word registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			head_value_q <= pop_ok ? cell_value_q[0] : '0;
			head_rank_q  <= pop_ok ? cell_rank_q[0] : '0;
			popped_q     <= pop_ok;
			if (is_push && full) begin
				status_q <= pos_pkg::STAT_FULL;
			end else if (is_pop && empty) begin
				status_q <= pos_pkg::STAT_EMPTY;
			end else begin
				status_q <= pos_pkg::STAT_OK;
			end
		end
	end

	assign head_value = head_value_q;
	assign head_rank  = head_rank_q;
	assign popped     = popped_q;
	assign status     = status_q;
	assign fill_count = occ_q;

endmodule

[design/priority_ordered_stack_unit.sv]
// top level of the priority ordered stack: controller plus cell datapath
// a command taken in the idle state moves the controller to the execute state, and its result
// word shows in the cycle after execute with done high for one cycle
// a new command is taken only in the idle state, so each command ends its execute state before the next is taken
// reset: arst_n clears the controller and the entry count; cell contents are not cleared
// the receiver cannot stall: each result word is valid for its one done cycle
`timescale 1ns / 1ps

module priority_ordered_stack_unit #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        kind,
	input  logic signed [31:0]                item_value,
	input  logic signed [31:0]                item_rank,
	output logic                              done,
	output logic signed [31:0]                head_value,
	output logic signed [31:0]                head_rank,
	output logic                              popped,
	output logic [1:0]                        status,
	output logic [$clog2(DEPTH + 1)-1:0]      fill_count
);

	localparam int CW = $clog2(DEPTH + 1);

	pos_pkg::cmd_t cmd;

	// sequencing
	pos_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// storage and compare cells
	pos_datapath #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.item_value (item_value),
		.item_rank  (item_rank),
		.head_value (head_value),
		.head_rank  (head_rank),
		.popped     (popped),
		.status     (status),
		.fill_count (fill_count)
	);

`ifndef SYNTHESIS
	// an accepted command executes on the following cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not enter execute");

	// a result word appears only once the unit is free again
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// entry count never exceeds the store size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= CW'(DEPTH))
		else $error("fill count beyond depth");

	// a returned entry always reports ok status
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && popped) |-> (status == pos_pkg::STAT_OK))
		else $error("popped word with error status");

	// a dropped push is reported only with a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == pos_pkg::STAT_FULL)) |-> (fill_count == CW'(DEPTH)))
		else $error("full status with room left");
`endif

endmodule

[verif/tb_priority_ordered_stack_unit.sv]
// testbench for the priority ordered stack unit: directed and random commands checked by a scoreboard
`timescale 1ns / 1ps

module tb_priority_ordered_stack_unit;

	localparam int DEPTH = 16;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int RANDOM_WORDS = 1330;
	localparam int IDLE_LIMIT = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam logic signed [31:0] RANK_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] RANK_MAX = 32'sh7fff_ffff;

	// expected stack contents and the result words they imply
	class stack_scoreboard;
		typedef struct {
			logic signed [31:0] value;
			logic signed [31:0] rank;
			logic               popped;
			logic [1:0]         status;
			logic [FILL_W-1:0]  fill;
		} result_word_t;

		logic signed [31:0] slot_value [DEPTH];
		logic signed [31:0] slot_rank [DEPTH];
		int                 occupancy;
		result_word_t       pending [$];
		int                 errors;

		function new();
			occupancy = 0;
			errors = 0;
		endfunction

		// shift entries down from pos and place the new entry there
		function void insert_entry(int pos, logic signed [31:0] v, logic signed [31:0] r);
			for (int i = occupancy; i > pos; i--) begin
				slot_value[i] = slot_value[i - 1];
				slot_rank[i] = slot_rank[i - 1];
			end
			slot_value[pos] = v;
			slot_rank[pos] = r;
			occupancy++;
		endfunction

		// apply one accepted command word and queue its result word
		function void note_command(logic [1:0] k, logic signed [31:0] v,
				logic signed [31:0] r);
			result_word_t res;
			int pos;
			res.value = '0;
			res.rank = '0;
			res.popped = 1'b0;
			res.status = pos_pkg::STAT_OK;
			if (k == pos_pkg::KIND_SORT || k == pos_pkg::KIND_FRONT) begin
				if (occupancy >= DEPTH) begin
					res.status = pos_pkg::STAT_FULL;
				end else if (k == pos_pkg::KIND_FRONT) begin
					insert_entry(0, v, r);
				end else begin
					// first stored entry with strictly greater rank
					pos = occupancy;
					for (int i = occupancy - 1; i >= 0; i--)
						if (slot_rank[i] > r) pos = i;
					insert_entry(pos, v, r);
				end
			end else if (k == pos_pkg::KIND_POP) begin
				if (occupancy == 0) begin
					res.status = pos_pkg::STAT_EMPTY;
				end else begin
					res.value = slot_value[0];
					res.rank = slot_rank[0];
					res.popped = 1'b1;
					for (int i = 1; i < occupancy; i++) begin
						slot_value[i - 1] = slot_value[i];
						slot_rank[i - 1] = slot_rank[i];
					end
					occupancy--;
				end
			end
			res.fill = occupancy[FILL_W-1:0];
			pending.push_back(res);
		endfunction

		function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
			if (act_val !== exp_val) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
					exp_val, act_val);
				errors++;
			end
		endfunction

		// compare one result word against the oldest expectation
		function void check_result(logic signed [31:0] v, logic signed [31:0] r,
				logic p, logic [1:0] s, logic [FILL_W-1:0] f);
			result_word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual value %0h rank %0h",
					$time, v, r);
				errors++;
			end else begin
				want = pending.pop_front();
				compare_field("head_value", want.value, v);
				compare_field("head_rank", want.rank, r);
				compare_field("popped", 32'(want.popped), 32'(p));
				compare_field("status", 32'(want.status), 32'(s));
				compare_field("fill_count", 32'(want.fill), 32'(f));
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               kind = pos_pkg::KIND_SORT;
	logic signed [31:0]       item_value = '0;
	logic signed [31:0]       item_rank = '0;
	logic                     done;
	logic signed [31:0]       head_value;
	logic signed [31:0]       head_rank;
	logic                     popped;
	logic [1:0]               status;
	logic [FILL_W-1:0]        fill_count;

	stack_scoreboard sb = new();
	int burst_left = 0;
	int idle_cycles = 0;

	priority_ordered_stack_unit #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.item_value(item_value),
		.item_rank(item_rank),
		.done(done),
		.head_value(head_value),
		.head_rank(head_rank),
		.popped(popped),
		.status(status),
		.fill_count(fill_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// note accepted command words and check result words
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_command(kind, item_value, item_rank);
		if (arst_n && done)
			sb.check_result(head_value, head_rank, popped, status, fill_count);
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// offer one command word, with random gaps between bursts
	task automatic send_word(logic [1:0] k, logic signed [31:0] v, logic signed [31:0] r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		start <= 1'b1;
		kind <= k;
		item_value <= v;
		item_rank <= r;
		do @(posedge clk); while (busy);
	endtask

	// ranks crowd into a narrow band so ties and extremes are common
	function automatic logic signed [31:0] pick_rank();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($signed($urandom_range(0, 8)) - 4);
			4: begin
				case ($urandom_range(0, 3))
					0: return RANK_MIN;
					1: return RANK_MAX;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int counted;
		int seg_left;
		int push_pct;
		int pick;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unused code, pop when empty, pop of the last entry
		send_word(KIND_NOP, $urandom, $urandom);
		send_word(pos_pkg::KIND_POP, $urandom, $urandom);
		send_word(pos_pkg::KIND_FRONT, 32'sh7fff_ffff, RANK_MAX);
		send_word(pos_pkg::KIND_POP, '0, '0);

		// directed: fill with extreme ranks, ties and head pushes
		send_word(pos_pkg::KIND_SORT, 32'sh8000_0000, RANK_MAX);
		send_word(pos_pkg::KIND_SORT, 32'sh0000_0001, RANK_MIN);
		send_word(pos_pkg::KIND_SORT, 32'shffff_ffff, 32'sd0);
		send_word(pos_pkg::KIND_SORT, 32'sh5555_5555, -32'sd1);
		send_word(pos_pkg::KIND_SORT, 32'shaaaa_aaaa, 32'sd5);
		send_word(pos_pkg::KIND_SORT, 32'sh1234_5678, 32'sd5);
		send_word(pos_pkg::KIND_FRONT, 32'sh0f0f_0f0f, RANK_MAX);
		send_word(pos_pkg::KIND_SORT, 32'shf0f0_f0f0, 32'sd5);
		send_word(pos_pkg::KIND_SORT, 32'sh7fff_ffff, RANK_MAX);
		send_word(pos_pkg::KIND_SORT, 32'sh0000_0000, RANK_MIN);
		for (int i = 0; i < 6; i++)
			send_word(($urandom_range(0, 3) == 0) ? pos_pkg::KIND_FRONT : pos_pkg::KIND_SORT,
				$urandom, pick_rank());

		// directed: pushes into a full stack, then a few pops
		send_word(pos_pkg::KIND_SORT, $urandom, 32'sd0);
		send_word(pos_pkg::KIND_FRONT, $urandom, RANK_MIN);
		send_word(pos_pkg::KIND_POP, '0, '0);
		send_word(pos_pkg::KIND_POP, '0, '0);

		// random segments, each leaning toward filling or draining
		counted = 0;
		seg_left = 0;
		push_pct = 50;
		while (counted < RANDOM_WORDS) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(8, 48);
				case ($urandom_range(0, 4))
					0: push_pct = 10;
					1: push_pct = 35;
					2: push_pct = 50;
					3: push_pct = 65;
					default: push_pct = 90;
				endcase
			end
			seg_left--;
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				send_word(KIND_NOP, $urandom, $urandom);
			end else begin
				counted++;
				if ($urandom_range(0, 99) < push_pct)
					send_word(($urandom_range(0, 3) == 0) ? pos_pkg::KIND_FRONT :
						pos_pkg::KIND_SORT, $urandom, pick_rank());
				else
					send_word(pos_pkg::KIND_POP, $urandom, $urandom);
			end
		end
		start <= 1'b0;

		// drain outstanding result words
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: result words missing, expected %0d more, actual 0", $time,
				sb.pending.size());
			sb.errors++;
		end

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
